[design/gcer_pkg.sv]
// ----------------------------------------------------------------------------
// gcer_pkg
// Shared types and constants for the gamepad change-event reporter.
// ----------------------------------------------------------------------------
package gcer_pkg;

  localparam int MAX_BUTTONS      = 16;
  localparam int MAX_AXES         = 4;
  localparam int NUM_BUTTONS_DEF  = 14;
  localparam int NUM_AXES_DEF     = 4;

  localparam int BTN_RAW_W  = 16;
  localparam int SAMPLE_W   = 16;
  localparam int DZ_W       = 15;
  localparam int INV_W      = 4;
  localparam int CH_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam int QUANT_SH   = 7;

  localparam logic [DZ_W-1:0]  DEADZONE_RST = 15'd1800;
  localparam logic [INV_W-1:0] INVERT_RST   = 4'd10;

  // logical button index -> physical bit
  localparam logic [3:0] PHYS_BIT [MAX_BUTTONS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd6, 4'd7, 4'd8, 4'd9,
    4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd4, 4'd5
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE = 1'b0,
    REG_INVERT   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_BUTTON = 1'b0,
    KIND_AXIS   = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic update;
    logic primed;
    logic fwd;
  } lane_ctrl_t;

endpackage

[design/gamepad_change_event_reporter.sv]
// ----------------------------------------------------------------------------
// gamepad_change_event_reporter
// Conditions one gamepad frame in parallel lanes and reports changed channels.
// ----------------------------------------------------------------------------
// Path: an input beat is registered, evaluated in ST_EVAL into the pending mask,
//   then each event is registered for out_valid. A new frame is accepted only
//   in idle, after every pending event has moved out; the event serializer
//   moves out one beat per cycle while out_ready does not stall it.
// Reset: synchronous active-low; registers return to deadzone 1800, invert
//   mask 10, zeroed history, unprimed (next frame reports every channel).
module gamepad_change_event_reporter #(
  parameter int NUM_BUTTONS = gcer_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = gcer_pkg::NUM_AXES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [gcer_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gcer_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [gcer_pkg::BTN_RAW_W-1:0]         in_buttons_raw,
  input  logic signed [gcer_pkg::SAMPLE_W-1:0]   in_left_x,
  input  logic signed [gcer_pkg::SAMPLE_W-1:0]   in_left_y,
  input  logic signed [gcer_pkg::SAMPLE_W-1:0]   in_right_x,
  input  logic signed [gcer_pkg::SAMPLE_W-1:0]   in_right_y,
  input  logic                                   in_forward,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_event_kind,
  output logic [gcer_pkg::CH_W-1:0]              out_channel,
  output logic signed [gcer_pkg::SAMPLE_W-1:0]   out_value,
  output logic                                   out_last_event
);

  localparam int NCH = NUM_BUTTONS + NUM_AXES;

  gcer_pkg::state_t                     state_r, state_nxt;
  logic [gcer_pkg::DZ_W-1:0]            deadzone_r, deadzone_nxt;
  logic [gcer_pkg::INV_W-1:0]           invert_r, invert_nxt;
  logic                                 primed_r, primed_nxt;
  logic [NUM_BUTTONS-1:0]               prev_btn_r, prev_btn_nxt;

  logic [gcer_pkg::BTN_RAW_W-1:0]       raw_r;
  logic signed [gcer_pkg::SAMPLE_W-1:0] samp_r [gcer_pkg::MAX_AXES];
  logic                                 fwd_r;

  logic                                 accept;
  logic                                 eval;
  logic                                 pend_empty;
  logic [NUM_BUTTONS-1:0]               btn_now;
  logic [NCH-1:0]                       chg_mask;
  logic signed [gcer_pkg::SAMPLE_W-1:0] axis_vals [NUM_AXES];
  gcer_pkg::lane_ctrl_t                 lane_ctrl;

  assign in_ready = (state_r == gcer_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign eval     = (state_r == gcer_pkg::ST_EVAL);

  assign lane_ctrl.update = eval;
  assign lane_ctrl.primed = primed_r;
  assign lane_ctrl.fwd    = fwd_r;

  // button lanes
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    assign btn_now[b]  = fwd_r && raw_r[gcer_pkg::PHYS_BIT[b]];
    assign chg_mask[b] = !primed_r || (btn_now[b] != prev_btn_r[b]);
  end

  // axis lanes
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    gcer_axis_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (lane_ctrl),
      .sample   (samp_r[a]),
      .invert   (invert_r[a]),
      .deadzone (deadzone_r),
      .value    (axis_vals[a]),
      .changed  (chg_mask[NUM_BUTTONS+a])
    );
  end

  gcer_merge #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_AXES    (NUM_AXES)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (eval),
    .chg_mask       (chg_mask),
    .btn_vals       (btn_now),
    .axis_vals      (axis_vals),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_event_kind (out_event_kind),
    .out_channel    (out_channel),
    .out_value      (out_value),
    .out_last_event (out_last_event),
    .pend_empty     (pend_empty)
  );

  always_comb begin
    state_nxt    = state_r;
    deadzone_nxt = deadzone_r;
    invert_nxt   = invert_r;
    primed_nxt   = primed_r;
    prev_btn_nxt = prev_btn_r;
    if (cfg_we) begin
      case (cfg_index)
        gcer_pkg::REG_DEADZONE: deadzone_nxt = cfg_wdata[gcer_pkg::DZ_W-1:0];
        gcer_pkg::REG_INVERT:   invert_nxt   = cfg_wdata[gcer_pkg::INV_W-1:0];
        default: ;
      endcase
    end
    case (state_r)
      gcer_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = gcer_pkg::ST_EVAL;
        end
      end
      gcer_pkg::ST_EVAL: begin
        prev_btn_nxt = btn_now;
        primed_nxt   = 1'b1;
        state_nxt    = gcer_pkg::ST_EMIT;
      end
      gcer_pkg::ST_EMIT: begin
        if (pend_empty) begin
          state_nxt = gcer_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gcer_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gcer_pkg::ST_IDLE;
      deadzone_r <= gcer_pkg::DEADZONE_RST;
      invert_r   <= gcer_pkg::INVERT_RST;
      primed_r   <= 1'b0;
      prev_btn_r <= '0;
    end else begin
      state_r    <= state_nxt;
      deadzone_r <= deadzone_nxt;
      invert_r   <= invert_nxt;
      primed_r   <= primed_nxt;
      prev_btn_r <= prev_btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r     <= in_buttons_raw;
      samp_r[0] <= in_left_x;
      samp_r[1] <= in_left_y;
      samp_r[2] <= in_right_x;
      samp_r[3] <= in_right_y;
      fwd_r     <= in_forward;
    end
  end

  a_first_frame_all: assert property (@(posedge clk) disable iff (!rst_n)
    (eval && !primed_r) |-> (&chg_mask))
    else $error("unprimed frame did not flag every channel");

  a_ready_idle_merge: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pend_empty)
    else $error("input ready while events still pending");

  a_eval_primes: assert property (@(posedge clk) disable iff (!rst_n)
    eval |=> primed_r)
    else $error("frame evaluated without priming history");

endmodule

[design/gcer_axis_lane.sv]
// ----------------------------------------------------------------------------
// gcer_axis_lane
// One axis: invert, clamp, deadzone, quantize, compare against last value.
// ----------------------------------------------------------------------------
module gcer_axis_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gcer_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [gcer_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 invert,
  input  logic [gcer_pkg::DZ_W-1:0]            deadzone,
  output logic signed [gcer_pkg::SAMPLE_W-1:0] value,
  output logic                                 changed
);

  logic signed [gcer_pkg::SAMPLE_W:0]   ext;
  logic signed [gcer_pkg::SAMPLE_W:0]   flipped;
  logic signed [gcer_pkg::SAMPLE_W:0]   clamped;
  logic [gcer_pkg::SAMPLE_W:0]          abs_v;
  logic [gcer_pkg::DZ_W-1:0]            mag;
  logic [gcer_pkg::DZ_W-1:0]            qmag;
  logic                                 neg;
  logic signed [gcer_pkg::SAMPLE_W-1:0] cond;
  logic signed [gcer_pkg::SAMPLE_W-1:0] prev_r;
  logic signed [gcer_pkg::SAMPLE_W-1:0] prev_nxt;

  always_comb begin
    ext     = {sample[gcer_pkg::SAMPLE_W-1], sample};
    flipped = invert ? -ext : ext;
    if (flipped > 17'sd32767) begin
      clamped = 17'sd32767;
    end else if (flipped < -17'sd32767) begin
      clamped = -17'sd32767;
    end else begin
      clamped = flipped;
    end
    neg   = clamped[gcer_pkg::SAMPLE_W];
    abs_v = neg ? 17'(-clamped) : 17'(clamped);
    mag   = abs_v[gcer_pkg::DZ_W-1:0];
    qmag  = {mag[gcer_pkg::DZ_W-1:gcer_pkg::QUANT_SH], {gcer_pkg::QUANT_SH{1'b0}}};
    if (mag < deadzone) begin
      cond = '0;
    end else if (neg) begin
      cond = -$signed({1'b0, qmag});
    end else begin
      cond = $signed({1'b0, qmag});
    end
    value    = ctrl.fwd ? cond : '0;
    changed  = !ctrl.primed || (value != prev_r);
    prev_nxt = ctrl.update ? value : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

[design/gcer_merge.sv]
// ----------------------------------------------------------------------------
// gcer_merge
// Collects lane change flags and serializes one event beat per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module gcer_merge #(
  parameter int NUM_BUTTONS = gcer_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = gcer_pkg::NUM_AXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [NUM_BUTTONS+NUM_AXES-1:0]      chg_mask,
  input  logic [NUM_BUTTONS-1:0]               btn_vals,
  input  logic signed [gcer_pkg::SAMPLE_W-1:0] axis_vals [NUM_AXES],
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_event_kind,
  output logic [gcer_pkg::CH_W-1:0]            out_channel,
  output logic signed [gcer_pkg::SAMPLE_W-1:0] out_value,
  output logic                                 out_last_event,
  output logic                                 pend_empty
);

  localparam int NCH = NUM_BUTTONS + NUM_AXES;

  logic [NCH-1:0]                       pend_r, pend_nxt;
  logic [NUM_BUTTONS-1:0]               btn_r;
  logic signed [gcer_pkg::SAMPLE_W-1:0] axis_r [NUM_AXES];
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 kind_r;
  logic [gcer_pkg::CH_W-1:0]            chan_r;
  logic signed [gcer_pkg::SAMPLE_W-1:0] val_r;
  logic                                 last_r;

  logic                                 found;
  logic [NCH-1:0]                       clr;
  logic                                 sel_kind;
  logic [gcer_pkg::CH_W-1:0]            sel_chan;
  logic signed [gcer_pkg::SAMPLE_W-1:0] sel_val;
  logic                                 take;

  always_comb begin
    found    = 1'b0;
    clr      = '0;
    sel_kind = gcer_pkg::KIND_BUTTON;
    sel_chan = '0;
    sel_val  = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (pend_r[b] && !found) begin
        found    = 1'b1;
        clr[b]   = 1'b1;
        sel_kind = gcer_pkg::KIND_BUTTON;
        sel_chan = gcer_pkg::CH_W'(b);
        sel_val  = $signed({{(gcer_pkg::SAMPLE_W-1){1'b0}}, btn_r[b]});
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      if (pend_r[NUM_BUTTONS+a] && !found) begin
        found              = 1'b1;
        clr[NUM_BUTTONS+a] = 1'b1;
        sel_kind           = gcer_pkg::KIND_AXIS;
        sel_chan           = gcer_pkg::CH_W'(a);
        sel_val            = axis_r[a];
      end
    end
    take = found && (!out_valid_r || out_ready);
    if (load) begin
      pend_nxt = chg_mask;
    end else if (take) begin
      pend_nxt = pend_r & ~clr;
    end else begin
      pend_nxt = pend_r;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      btn_r  <= btn_vals;
      axis_r <= axis_vals;
    end
    if (take) begin
      kind_r <= sel_kind;
      chan_r <= sel_chan;
      val_r  <= sel_val;
      last_r <= ((pend_r & ~clr) == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_channel    = chan_r;
  assign out_value      = val_r;
  assign out_last_event = last_r;
  assign pend_empty     = (pend_r == '0);

  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (pend_r == '0))
    else $error("new frame loaded over pending events");

  a_nonlast_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (pend_r != '0))
    else $error("non-last beat shown with no events remaining");

  a_pending_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ((pend_r != '0) && !out_valid_r) |=> out_valid_r)
    else $error("pending event not moved to output");

endmodule
